FILE: src/v3n_pkg.sv
// ----------------------------------------------------------------------------
// v3n_pkg
// Shared widths for the vector normalisation block.
// ----------------------------------------------------------------------------
package v3n_pkg;
  localparam int unsigned OutW = 32;  // Q2.30 result width
  localparam int unsigned QuoW = 31;  // quotient bits, 2^30 fits
  localparam int unsigned ThrW = 31;  // threshold register width
endpackage

FILE: src/v3n_vec_if.sv
// ----------------------------------------------------------------------------
// v3n_vec_if
// Input channel: one Q16.16 vector per item.
// ----------------------------------------------------------------------------
interface v3n_vec_if #(
  parameter int unsigned COMP_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [COMP_WIDTH-1:0] comp_x;
  logic signed [COMP_WIDTH-1:0] comp_y;
  logic signed [COMP_WIDTH-1:0] comp_z;
  modport source (output valid, comp_x, comp_y, comp_z, input ready);
  modport sink   (input valid, comp_x, comp_y, comp_z, output ready);
endinterface

FILE: src/v3n_unit_if.sv
// ----------------------------------------------------------------------------
// v3n_unit_if
// Output channel: one normalised Q2.30 vector per item.
// ----------------------------------------------------------------------------
interface v3n_unit_if import v3n_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [OutW-1:0] unit_x;
  logic signed [OutW-1:0] unit_y;
  logic signed [OutW-1:0] unit_z;
  logic                   too_short;
  modport source (output valid, unit_x, unit_y, unit_z, too_short, input ready);
  modport sink   (input valid, unit_x, unit_y, unit_z, too_short, output ready);
endinterface

FILE: src/v3n_front.sv
// ----------------------------------------------------------------------------
// v3n_front
// Take magnitudes and signs, square, and sum into the queue word.
// ----------------------------------------------------------------------------
module v3n_front #(
  parameter int unsigned COMP_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  v3n_vec_if.sink                       in_i,
  output logic                          push_o,
  input  logic                          full_i,
  output logic [3*COMP_WIDTH-1:0]       mag_o,
  output logic [2:0]                    neg_o,
  output logic [2*COMP_WIDTH-1:0]       sum_o
);
  localparam int unsigned CW = COMP_WIDTH;
  localparam int unsigned SW = 2 * COMP_WIDTH;

  logic                 a_v_q, b_v_q;
  logic [2:0][CW-1:0]   a_mag_q, b_mag_q;
  logic [2:0]           a_neg_q, b_neg_q;
  logic [2:0][SW-1:0]   b_sq_q;
  logic [2:0][CW-1:0]   raw;
  logic [2:0][CW-1:0]   mag_d;
  logic [2:0]           neg_d;
  logic                 b_rdy, a_rdy;

  assign raw   = {in_i.comp_z, in_i.comp_y, in_i.comp_x};
  assign b_rdy = !b_v_q || !full_i;
  assign a_rdy = !a_v_q || b_rdy;
  assign in_i.ready = a_rdy;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_d[i] = raw[i][CW-1];
      mag_d[i] = neg_d[i] ? (~raw[i] + 1'b1) : raw[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
    end else begin
      if (a_rdy) a_v_q <= in_i.valid;
      if (b_rdy) b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_rdy) begin
      a_mag_q <= mag_d;
      a_neg_q <= neg_d;
    end
    if (b_rdy) begin
      b_mag_q <= a_mag_q;
      b_neg_q <= a_neg_q;
      for (int i = 0; i < 3; i++) b_sq_q[i] <= SW'(a_mag_q[i]) * SW'(a_mag_q[i]);
    end
  end

  assign push_o = b_v_q && !full_i;
  assign mag_o  = b_mag_q;
  assign neg_o  = b_neg_q;
  assign sum_o  = b_sq_q[0] + b_sq_q[1] + b_sq_q[2];
endmodule

FILE: src/v3n_queue.sv
// ----------------------------------------------------------------------------
// v3n_queue
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
module v3n_queue #(
  parameter int unsigned DATA_WIDTH = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic [DATA_WIDTH-1:0] data_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  avail_o,
  output logic [DATA_WIDTH-1:0] data_o
);
  logic [1:0][DATA_WIDTH-1:0] mem_q;
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q[1];
  assign avail_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end
endmodule

FILE: src/v3n_back.sv
// ----------------------------------------------------------------------------
// v3n_back
// Pipelined square root, then pipelined restoring division, one bit a stage.
// ----------------------------------------------------------------------------
module v3n_back import v3n_pkg::*; #(
  parameter int unsigned COMP_WIDTH = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      avail_i,
  output logic                      pop_o,
  input  logic [3*COMP_WIDTH-1:0]   mag_i,
  input  logic [2:0]                neg_i,
  input  logic [2*COMP_WIDTH-1:0]   sum_i,
  input  logic [ThrW-1:0]           thresh_i,
  v3n_unit_if.source                out_o
);
  localparam int unsigned CW   = COMP_WIDTH;
  localparam int unsigned SW   = 2 * COMP_WIDTH;
  localparam int unsigned NS   = COMP_WIDTH + QuoW;
  localparam int unsigned CMPW = (COMP_WIDTH > ThrW) ? COMP_WIDTH : ThrW;

  typedef struct packed {
    logic                  v;
    logic [SW-1:0]         sum;
    logic [CW+1:0]         rem;
    logic [CW-1:0]         root;
    logic [2:0][CW:0]      r;
    logic [2:0][QuoW-1:0]  q;
    logic [2:0]            neg;
  } stg_t;

  stg_t       stg_in [NS];
  stg_t       stg_nx [NS];
  stg_t       stg_q  [NS];
  stg_t       last;
  logic       adv;
  logic [2:0][CW-1:0]  mag;
  logic [2:0][OutW-1:0] unit;
  logic       short;

  // Whole pipeline moves together; last stage is the output register.
  assign adv   = !stg_q[NS-1].v || out_o.ready;
  assign pop_o = adv && avail_i;
  assign mag   = mag_i;

  always_comb begin
    stg_in[0]      = '0;
    stg_in[0].v    = avail_i;
    stg_in[0].sum  = sum_i;
    stg_in[0].neg  = neg_i;
    for (int i = 0; i < 3; i++) stg_in[0].r[i] = {1'b0, mag[i]};
  end

  for (genvar s = 0; s < NS; s++) begin : g_stg
    if (s > 0) begin : g_link
      assign stg_in[s] = stg_q[s-1];
    end

    if (s < CW) begin : g_sqrt
      logic [CW+3:0] rx;
      logic [CW+3:0] trial;
      always_comb begin
        stg_nx[s]     = stg_in[s];
        rx            = {stg_in[s].rem, stg_in[s].sum[SW-1 -: 2]};
        trial         = {2'b00, stg_in[s].root, 2'b01};
        stg_nx[s].sum = {stg_in[s].sum[SW-3:0], 2'b00};
        if (rx >= trial) begin
          stg_nx[s].rem  = (CW+2)'(rx - trial);
          stg_nx[s].root = {stg_in[s].root[CW-2:0], 1'b1};
        end else begin
          stg_nx[s].rem  = (CW+2)'(rx);
          stg_nx[s].root = {stg_in[s].root[CW-2:0], 1'b0};
        end
      end
    end else begin : g_div
      logic [2:0][CW:0] rs;
      always_comb begin
        stg_nx[s] = stg_in[s];
        for (int i = 0; i < 3; i++) begin
          rs[i] = (s == CW) ? stg_in[s].r[i] : {stg_in[s].r[i][CW-1:0], 1'b0};
          if (rs[i] >= {1'b0, stg_in[s].root}) begin
            stg_nx[s].r[i] = rs[i] - {1'b0, stg_in[s].root};
            stg_nx[s].q[i] = {stg_in[s].q[i][QuoW-2:0], 1'b1};
          end else begin
            stg_nx[s].r[i] = rs[i];
            stg_nx[s].q[i] = {stg_in[s].q[i][QuoW-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stg_q[s] <= '0;
      end else if (adv) begin
        stg_q[s] <= stg_nx[s];
      end
    end
  end

  assign last  = stg_q[NS-1];
  assign short = CMPW'(last.root) < CMPW'(thresh_i);

  // Zero vector on short length, and also on zero length with zero threshold.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (short || last.root == '0) unit[i] = '0;
      else if (last.neg[i])         unit[i] = -OutW'(last.q[i]);
      else                          unit[i] = OutW'(last.q[i]);
    end
  end

  assign out_o.valid     = last.v;
  assign out_o.unit_x    = unit[0];
  assign out_o.unit_y    = unit[1];
  assign out_o.unit_z    = unit[2];
  assign out_o.too_short = short;
endmodule

FILE: src/vector3_normalize_core.sv
// ----------------------------------------------------------------------------
// vector3_normalize_core
// Scales a Q16.16 3D vector to unit length in Q2.30.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one vector per item (comp_x/y/z, signed Q16.16); out_o
//   returns one item per input: unit_x/y/z (Q2.30, truncated toward zero)
//   and too_short, set with a zero vector when the length falls below
//   zero_threshold. Write the threshold through cfg_we_i/cfg_data_i while
//   the block is idle; reset loads 7.
//   Throughput is one item per cycle while out_o does not stall. An item
//   passes the front stages and the queue, then COMP_WIDTH root stages
//   and 31 divider stages; the root loop and the quotient loop each cost
//   one pipeline stage per result bit.
//   When out_o stalls, the back pipeline holds; the two-entry queue absorbs
//   what the front has in flight, then in_i.ready drops.
//   Reset clears all valid flags and the queue, and reloads the threshold
//   with 7.
// ----------------------------------------------------------------------------
module vector3_normalize_core import v3n_pkg::*; #(
  parameter int unsigned COMP_WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  v3n_vec_if.sink          in_i,
  v3n_unit_if.source       out_o,
  input  logic             cfg_we_i,
  input  logic [ThrW-1:0]  cfg_data_i
);
  localparam int unsigned QDW = 3 * COMP_WIDTH + 3 + 2 * COMP_WIDTH;

  logic [ThrW-1:0]           thresh_q;
  logic                      push, full, pop, avail;
  logic [3*COMP_WIDTH-1:0]   f_mag, b_mag;
  logic [2:0]                f_neg, b_neg;
  logic [2*COMP_WIDTH-1:0]   f_sum, b_sum;

  // Threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= ThrW'(7);
    end else if (cfg_we_i) begin
      thresh_q <= cfg_data_i;
    end
  end

  // Front: magnitudes, squares and their sum
  v3n_front #(.COMP_WIDTH(COMP_WIDTH)) u_front (
    .clk_i, .rst_ni, .in_i,
    .push_o(push), .full_i(full),
    .mag_o(f_mag), .neg_o(f_neg), .sum_o(f_sum)
  );

  // Decouple front and back
  v3n_queue #(.DATA_WIDTH(QDW)) u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .data_i({f_mag, f_neg, f_sum}), .full_o(full),
    .pop_i(pop), .avail_o(avail), .data_o({b_mag, b_neg, b_sum})
  );

  // Back: root, divide, threshold test
  v3n_back #(.COMP_WIDTH(COMP_WIDTH)) u_back (
    .clk_i, .rst_ni,
    .avail_i(avail), .pop_o(pop),
    .mag_i(b_mag), .neg_i(b_neg), .sum_i(b_sum),
    .thresh_i(thresh_q), .out_o
  );
endmodule

FILE: verif/vector3_normalize_core_tb.sv
// ----------------------------------------------------------------------------
// vector3_normalize_core_tb
// Self-checking bench for the vector normalisation core: directed and random
// vectors under several zero thresholds. A local predictor computes each
// unit vector, and a monitor compares every returned item field by field.
// ----------------------------------------------------------------------------
module vector3_normalize_core_tb import v3n_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CompW     = 32;
  localparam int unsigned Latency   = CompW + 34;
  localparam int unsigned CycleCap  = 400000;
  localparam int unsigned PhaseLen  = 300;

  typedef struct {
    logic signed [CompW-1:0] x, y, z;
  } vec_t;

  typedef struct {
    logic signed [OutW-1:0] x, y, z;
    logic                   short_flag;
  } unit_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [ThrW-1:0] cfg_data_i = '0;

  v3n_vec_if #(.COMP_WIDTH(CompW)) vec_ch ();
  v3n_unit_if unit_ch ();

  vector3_normalize_core #(.COMP_WIDTH(CompW)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (vec_ch.sink),
    .out_o      (unit_ch.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  vec_t  pending_vecs[$];
  unit_t expected_units[$];
  logic [ThrW-1:0] threshold = ThrW'(7);
  int unsigned cycle_cnt = 0;
  int unsigned sent_cnt = 0;
  int unsigned checked_cnt = 0;
  int unsigned short_cnt = 0;
  int unsigned err_cnt = 0;

  // Floor square root of a 128-bit value, two bits per step.
  function automatic logic [127:0] floor_root(input logic [127:0] s);
    logic [127:0] rem, root, trial;
    rem = '0;
    root = '0;
    for (int p = 126; p >= 0; p -= 2) begin
      rem = (rem << 2) | s[p+:2];
      trial = (root << 2) | 128'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 128'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic unit_t normalise(input vec_t v, input logic [ThrW-1:0] thr);
    logic [CompW-1:0] mag[3];
    logic             neg[3];
    logic signed [CompW-1:0] c[3];
    logic [127:0] sum, len;
    logic [63:0]  q;
    logic [OutW-1:0] r[3];
    unit_t u;
    c[0] = v.x;
    c[1] = v.y;
    c[2] = v.z;
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = c[i][CompW-1];
      // Take the most negative value at full magnitude: it fits unsigned.
      mag[i] = neg[i] ? (~c[i] + 1'b1) : c[i];
      sum = sum + 128'(64'(mag[i]) * 64'(mag[i]));
    end
    len = floor_root(sum);
    if (len < 128'(thr)) begin
      u.x = '0;
      u.y = '0;
      u.z = '0;
      u.short_flag = 1'b1;
      return u;
    end
    for (int i = 0; i < 3; i++) begin
      // Zero length with zero threshold: skip the division, give zero.
      q = (len == 0) ? 64'd0 : ((64'(mag[i]) << 30) / len[63:0]);
      r[i] = neg[i] ? OutW'(-q) : OutW'(q);
    end
    u.x = r[0];
    u.y = r[1];
    u.z = r[2];
    u.short_flag = 1'b0;
    return u;
  endfunction

  // Give idle gaps everywhere except one long calm stretch.
  function automatic logic roll_idle(input int unsigned cyc);
    if (cyc >= 1000 && cyc < 1600) return 1'b0;
    return ($urandom_range(99) < 10);
  endfunction

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleCap) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("[vector3_normalize_core] ERROR");
      $finish;
    end
  end

  // Driver: advance the queue on each accepted item, hold while stalled.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vec_ch.valid  <= 1'b0;
      vec_ch.comp_x <= '0;
      vec_ch.comp_y <= '0;
      vec_ch.comp_z <= '0;
    end else begin
      if (vec_ch.valid && vec_ch.ready) begin
        expected_units.push_back(normalise(pending_vecs[0], threshold));
        pending_vecs.pop_front();
        sent_cnt <= sent_cnt + 1;
      end
      if (vec_ch.valid && !vec_ch.ready) begin
        // hold the offered item untouched
      end else if (pending_vecs.size() > 0 && !roll_idle(cycle_cnt)) begin
        vec_ch.valid  <= 1'b1;
        vec_ch.comp_x <= pending_vecs[0].x;
        vec_ch.comp_y <= pending_vecs[0].y;
        vec_ch.comp_z <= pending_vecs[0].z;
      end else begin
        vec_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: random back-pressure, compare each accepted item in order.
  always @(posedge clk_i or negedge rst_ni) begin
    unit_t e;
    if (!rst_ni) begin
      unit_ch.ready <= 1'b0;
    end else begin
      unit_ch.ready <= !roll_idle(cycle_cnt);
      if (unit_ch.valid && unit_ch.ready) begin
        if (expected_units.size() == 0) begin
          $error("unexpected result item: x=%0d y=%0d z=%0d short=%0b",
                 unit_ch.unit_x, unit_ch.unit_y, unit_ch.unit_z, unit_ch.too_short);
          err_cnt <= err_cnt + 1;
        end else begin
          e = expected_units.pop_front();
          checked_cnt <= checked_cnt + 1;
          if (e.short_flag) short_cnt <= short_cnt + 1;
          if (unit_ch.unit_x !== e.x) begin
            $error("unit_x expected %0d got %0d", e.x, unit_ch.unit_x);
            err_cnt <= err_cnt + 1;
          end
          if (unit_ch.unit_y !== e.y) begin
            $error("unit_y expected %0d got %0d", e.y, unit_ch.unit_y);
            err_cnt <= err_cnt + 1;
          end
          if (unit_ch.unit_z !== e.z) begin
            $error("unit_z expected %0d got %0d", e.z, unit_ch.unit_z);
            err_cnt <= err_cnt + 1;
          end
          if (unit_ch.too_short !== e.short_flag) begin
            $error("too_short expected %0b got %0b", e.short_flag, unit_ch.too_short);
            err_cnt <= err_cnt + 1;
          end
        end
      end
    end
  end

  task automatic queue_vec(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
    vec_t v;
    v.x = x;
    v.y = y;
    v.z = z;
    pending_vecs.push_back(v);
  endtask

  // Component drawn from a mix of tiny, moderate, full-range and extreme values.
  function automatic logic [31:0] rand_comp();
    case ($urandom_range(5))
      0: return 32'($signed($urandom_range(40)) - 20);
      1: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Wait until every item has gone through and every result has come back.
  task automatic drain();
    while (pending_vecs.size() != 0 || vec_ch.valid || expected_units.size() != 0)
      @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [ThrW-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    threshold = value;
  endtask

  task automatic run_random(input int unsigned n);
    for (int i = 0; i < n; i++) begin
      @(negedge clk_i);
      queue_vec(rand_comp(), rand_comp(), rand_comp());
    end
  endtask

  initial begin
    logic [ThrW-1:0] settings[5];
    settings[0] = '0;
    settings[1] = {ThrW{1'b1}};
    settings[2] = ThrW'(32'h0001_0000);
    settings[3] = ThrW'($urandom_range(1 << 12));
    settings[4] = ThrW'($urandom);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed vectors at the reset threshold.
    @(negedge clk_i);
    queue_vec(32'd0, 32'd0, 32'd0);
    queue_vec(32'd1, 32'd2, 32'd2);
    queue_vec(32'd7, 32'd0, 32'd0);
    queue_vec(32'd6, 32'd0, 32'd0);
    queue_vec(-32'sd7, 32'd0, 32'd0);
    queue_vec(32'h0001_0000, 32'd0, 32'd0);
    queue_vec(32'd0, -32'sh0001_0000, 32'd0);
    queue_vec(32'd0, 32'd0, 32'h0001_0000);
    queue_vec(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    queue_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    queue_vec(32'h8000_0000, 32'd0, 32'd0);
    queue_vec(32'h7fff_ffff, 32'h8000_0000, 32'd1);
    queue_vec(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    queue_vec(32'd3, 32'd4, 32'd12);
    queue_vec(32'h0003_0000, -32'sh0004_0000, 32'h000c_0000);
    drain();

    // Zero vector with a zero threshold takes the no-division path.
    write_threshold(settings[0]);
    @(negedge clk_i);
    queue_vec(32'd0, 32'd0, 32'd0);
    queue_vec(32'd1, 32'd0, 32'd0);
    queue_vec(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    run_random(PhaseLen);
    drain();

    for (int s = 1; s < 5; s++) begin
      write_threshold(settings[s]);
      run_random(PhaseLen);
      drain();
    end

    // Back to the reset value for a final burst.
    write_threshold(ThrW'(7));
    run_random(100);
    drain();

    $display("checked %0d of %0d vectors (%0d short) over six threshold settings",
             checked_cnt, sent_cnt, short_cnt);
    if (err_cnt == 0 && expected_units.size() == 0) begin
      $display("[vector3_normalize_core] OK");
    end else begin
      $display("[vector3_normalize_core] ERROR");
    end
    $finish;
  end
endmodule
